>>> design/assert_macros.svh
// assertion macros used by pap_checker
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset only
`define PAP_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define PAP_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> design/pap_pkg.sv
// constants and types for the polygon area and perimeter block
// no dependencies
package pap_pkg;

    localparam int COORD_BITS  = 24;
    localparam int MAX_CORNERS = 4096;

    localparam int MUL_W   = COORD_BITS + 1;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int SQ_W    = PROD_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int STEP_W  = $clog2(ROOT_W);
    localparam int CNT_W   = $clog2(MAX_CORNERS + 1);

    localparam int AREA_W  = 63;
    localparam int ACC_W   = 64;
    localparam int PERIM_W = 40;
    localparam int COUNT_W = 13;
    localparam int LIMIT_W = 62;

    localparam logic signed [ACC_W-1:0] AREA_HI = {2'b00, {(ACC_W-2){1'b1}}};
    localparam logic signed [ACC_W-1:0] AREA_LO = {2'b11, {(ACC_W-2){1'b0}}};
    localparam logic [PERIM_W-1:0]      PERIM_SAT = {PERIM_W{1'b1}};

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [MUL_W-1:0]      operand_t;
    typedef logic signed [PROD_W-1:0]     product_t;
    typedef logic [SQ_W-1:0]              radicand_t;
    typedef logic [ROOT_W-1:0]            root_t;
    typedef logic signed [AREA_W-1:0]     area_t;
    typedef logic [PERIM_W-1:0]           perim_t;
    typedef logic [COUNT_W-1:0]           count_t;
    typedef logic [LIMIT_W-1:0]           limit_t;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_PREP     = 8'b0000_0010,
        S_MUL_AREA = 8'b0000_0100,
        S_MUL_DX   = 8'b0000_1000,
        S_MUL_DY   = 8'b0001_0000,
        S_SQ_SUM   = 8'b0010_0000,
        S_ROOT     = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

endpackage

>>> design/pap_if.sv
// handshake channels of the polygon area and perimeter block
// depends on pap_pkg
interface pap_vertex_if;
    import pap_pkg::*;
    logic   valid;
    logic   ready;
    coord_t vertex_x;
    coord_t vertex_y;
    logic   ring_end;
    modport source (output valid, output vertex_x, output vertex_y, output ring_end,
                    input ready);
    modport sink (input valid, input vertex_x, input vertex_y, input ring_end,
                  output ready);
endinterface

interface pap_result_if;
    import pap_pkg::*;
    logic   valid;
    logic   ready;
    area_t  twice_area;
    perim_t perimeter;
    logic   is_hole;
    logic   is_tiny;
    count_t corner_count;
    modport source (output valid, output twice_area, output perimeter, output is_hole,
                    output is_tiny, output corner_count, input ready);
    modport sink (input valid, input twice_area, input perimeter, input is_hole,
                  input is_tiny, input corner_count, output ready);
endinterface

interface pap_cfg_if;
    import pap_pkg::*;
    logic   valid;
    logic   ready;
    limit_t tiny_area_limit;
    modport source (output valid, output tiny_area_limit, input ready);
    modport sink (input valid, input tiny_area_limit, output ready);
endinterface

>>> design/pap_mul.sv
// shared signed multiplier with registered product
// depends on pap_pkg
module pap_mul (
    input  logic              clk,
    input  pap_pkg::operand_t op_a,
    input  pap_pkg::operand_t op_b,
    output pap_pkg::product_t prod
);
    import pap_pkg::*;

    product_t prod_reg;
    product_t prod_next;

    assign prod_next = PROD_W'(op_a) * PROD_W'(op_b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

>>> design/pap_isqrt.sv
// bit-serial floor square root, two radicand bits per cycle
// depends on pap_pkg
module pap_isqrt (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  pap_pkg::radicand_t radicand,
    output logic               done,
    output pap_pkg::root_t     root
);
    import pap_pkg::*;

    radicand_t         rad_reg, rad_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    root_t             root_reg, root_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    logic [REM_W+1:0]  cand;
    logic [REM_W+1:0]  trial;

    always_comb
    begin
        cand      = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial     = (REM_W+2)'({root_reg, 2'b01});
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (busy_reg)
        begin
            rad_next = {rad_reg[SQ_W-3:0], 2'b00};
            if (cand >= trial)
            begin
                rem_next  = REM_W'(cand - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = REM_W'(cand);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(ROOT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (start)
        begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> design/polygon_area_perimeter.sv
// polygon twice-area and perimeter accumulator, top level
// depends on pap_pkg, pap_if, pap_mul and pap_isqrt
//
// usage:
//   vertex: one beat per polygon vertex, x and y signed fixed point; ring_end
//     marks the last vertex of a polygon. the next beat starts a new polygon.
//   result: one beat per polygon after its last vertex: twice area (clockwise
//     positive, saturating), perimeter as a sum of floored edge lengths,
//     hole and tiny flags and the vertex count.
//   cfg: writes the tiny area limit; always ready, write only while idle.
// timing:
//   a first vertex that does not end its polygon is only stored. each further
//   vertex is accepted, then runs prep, the shared multiplier and adders, and
//   the bit-serial square root (25 root bits, one a cycle, then the done
//   cycle). a last vertex runs the closing edge too, a lone vertex only its
//   closing edge onto itself; the result is valid from the cycle in which
//   vertex ready returns. the square root loop sets the rate.
//   a result waits in its output register while the receiver stalls; the
//   next polygon is worked on meanwhile and stops only at its own result.
// reset: clears the sequencer, vertex count, result valid and the limit.
module polygon_area_perimeter (
    input  logic                clk,
    input  logic                rst_n,
    pap_cfg_if.sink             cfg,
    pap_vertex_if.sink          vertex,
    pap_result_if.source        result
);
    import pap_pkg::*;

    state_t state_reg, state_next;

    coord_t first_x_reg, first_x_next, first_y_reg, first_y_next;
    coord_t prev_x_reg, prev_x_next, prev_y_reg, prev_y_next;
    coord_t ax_reg, ax_next, ay_reg, ay_next, bx_reg, bx_next, by_reg, by_next;

    operand_t  sum_reg, sum_next, dx_reg, dx_next, dy_reg, dy_next;
    radicand_t sq_reg, sq_next;
    area_t     area_reg, area_next;
    perim_t    perim_reg, perim_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic      last_reg, last_next;
    logic      closing_reg, closing_next;
    limit_t    limit_reg;

    logic   out_valid_reg, out_valid_next;
    area_t  out_area_reg, out_area_next;
    perim_t out_perim_reg, out_perim_next;
    logic   out_hole_reg, out_hole_next;
    logic   out_tiny_reg, out_tiny_next;
    count_t out_count_reg, out_count_next;

    operand_t  mul_a, mul_b;
    product_t  prod;
    logic      root_start;
    radicand_t radicand;
    logic      root_done;
    root_t     root;

    logic signed [ACC_W-1:0] area_sum;
    logic [PERIM_W:0]        perim_sum;
    logic [AREA_W-1:0]       area_mag;

    logic vertex_beat;

    pap_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    pap_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .radicand (radicand),
        .done     (root_done),
        .root     (root)
    );

    assign vertex.ready = (state_reg == S_IDLE);
    assign vertex_beat  = vertex.valid && vertex.ready;
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        case (state_reg)
            S_MUL_AREA:
            begin
                mul_a = sum_reg;
                mul_b = dy_reg;
            end
            S_MUL_DX:
            begin
                mul_a = dx_reg;
                mul_b = dx_reg;
            end
            default:
            begin
                mul_a = dy_reg;
                mul_b = dy_reg;
            end
        endcase
    end

    // shoelace term is minus the product, clamped after every edge
    assign area_sum   = ACC_W'(area_reg) - ACC_W'(prod);
    assign radicand   = sq_reg + radicand_t'(prod);
    assign root_start = (state_reg == S_SQ_SUM);
    assign perim_sum  = {1'b0, perim_reg} + (PERIM_W+1)'(root);
    assign area_mag   = area_reg[AREA_W-1] ? AREA_W'(-area_reg) : AREA_W'(area_reg);

    always_comb
    begin
        state_next     = state_reg;
        first_x_next   = first_x_reg;
        first_y_next   = first_y_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        bx_next        = bx_reg;
        by_next        = by_reg;
        sum_next       = sum_reg;
        dx_next        = dx_reg;
        dy_next        = dy_reg;
        sq_next        = sq_reg;
        area_next      = area_reg;
        perim_next     = perim_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        closing_next   = closing_reg;
        out_valid_next = out_valid_reg;
        out_area_next  = out_area_reg;
        out_perim_next = out_perim_reg;
        out_hole_next  = out_hole_reg;
        out_tiny_next  = out_tiny_reg;
        out_count_next = out_count_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (vertex_beat)
                begin
                    last_next   = vertex.ring_end;
                    prev_x_next = vertex.vertex_x;
                    prev_y_next = vertex.vertex_y;
                    bx_next     = vertex.vertex_x;
                    by_next     = vertex.vertex_y;
                    if (cnt_reg == '0)
                    begin
                        // first vertex: a lone vertex closes onto itself
                        first_x_next = vertex.vertex_x;
                        first_y_next = vertex.vertex_y;
                        ax_next      = vertex.vertex_x;
                        ay_next      = vertex.vertex_y;
                        area_next    = '0;
                        perim_next   = '0;
                        cnt_next     = CNT_W'(1);
                        closing_next = 1'b1;
                        if (vertex.ring_end)
                        begin
                            state_next = S_PREP;
                        end
                    end
                    else
                    begin
                        ax_next      = prev_x_reg;
                        ay_next      = prev_y_reg;
                        closing_next = 1'b0;
                        if (cnt_reg < CNT_W'(MAX_CORNERS))
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                        state_next = S_PREP;
                    end
                end
            end
            S_PREP:
            begin
                sum_next   = MUL_W'(ax_reg) + MUL_W'(bx_reg);
                dx_next    = MUL_W'(bx_reg) - MUL_W'(ax_reg);
                dy_next    = MUL_W'(by_reg) - MUL_W'(ay_reg);
                state_next = S_MUL_AREA;
            end
            S_MUL_AREA:
            begin
                state_next = S_MUL_DX;
            end
            S_MUL_DX:
            begin
                if (area_sum > AREA_HI)
                begin
                    area_next = AREA_W'(AREA_HI);
                end
                else if (area_sum < AREA_LO)
                begin
                    area_next = AREA_W'(AREA_LO);
                end
                else
                begin
                    area_next = AREA_W'(area_sum);
                end
                state_next = S_MUL_DY;
            end
            S_MUL_DY:
            begin
                sq_next    = radicand_t'(prod);
                state_next = S_SQ_SUM;
            end
            S_SQ_SUM:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    perim_next = perim_sum[PERIM_W] ? PERIM_SAT : perim_sum[PERIM_W-1:0];
                    if (closing_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else if (last_reg)
                    begin
                        ax_next      = prev_x_reg;
                        ay_next      = prev_y_reg;
                        bx_next      = first_x_reg;
                        by_next      = first_y_reg;
                        closing_next = 1'b1;
                        state_next   = S_PREP;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DONE:
            begin
                // wait here only if an older result is still held
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_area_next  = area_reg;
                    out_perim_next = perim_reg;
                    out_hole_next  = area_reg[AREA_W-1];
                    out_tiny_next  = area_mag < AREA_W'(limit_reg);
                    out_count_next = COUNT_W'(cnt_reg);
                    cnt_next       = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                limit_reg <= cfg.tiny_area_limit;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        first_x_reg   <= first_x_next;
        first_y_reg   <= first_y_next;
        prev_x_reg    <= prev_x_next;
        prev_y_reg    <= prev_y_next;
        ax_reg        <= ax_next;
        ay_reg        <= ay_next;
        bx_reg        <= bx_next;
        by_reg        <= by_next;
        sum_reg       <= sum_next;
        dx_reg        <= dx_next;
        dy_reg        <= dy_next;
        sq_reg        <= sq_next;
        area_reg      <= area_next;
        perim_reg     <= perim_next;
        last_reg      <= last_next;
        closing_reg   <= closing_next;
        out_area_reg  <= out_area_next;
        out_perim_reg <= out_perim_next;
        out_hole_reg  <= out_hole_next;
        out_tiny_reg  <= out_tiny_next;
        out_count_reg <= out_count_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.twice_area   = out_area_reg;
    assign result.perimeter    = out_perim_reg;
    assign result.is_hole      = out_hole_reg;
    assign result.is_tiny      = out_tiny_reg;
    assign result.corner_count = out_count_reg;

endmodule

>>> design/pap_checker.sv
// port-level checks of the polygon area and perimeter block, bound to the top
// depends on pap_pkg and assert_macros.svh
`include "assert_macros.svh"

module pap_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            in_ring_end,
    input logic            out_valid,
    input logic            out_ready,
    input pap_pkg::area_t  out_area,
    input pap_pkg::perim_t out_perim,
    input pap_pkg::count_t out_count
);
    import pap_pkg::*;

    `PAP_ASSERT_ALWAYS(a_no_result_in_reset, clk, !rst_n |-> !out_valid, "result valid in reset")

    `PAP_ASSERT(a_result_held, clk, rst_n, out_valid && !out_ready |=> out_valid, "result dropped")

    `PAP_ASSERT(a_payload_held, clk, rst_n, out_valid && !out_ready |=> $stable(out_area) && $stable(out_perim), "stalled result changed")

    `PAP_ASSERT(a_busy_after_ring, clk, rst_n, in_valid && in_ready && in_ring_end |=> !in_ready, "ready after last vertex beat")

    `PAP_ASSERT(a_count_nonzero, clk, rst_n, out_valid |-> out_count != '0, "result with no vertices")

endmodule

bind polygon_area_perimeter pap_checker u_pap_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (vertex.valid),
    .in_ready    (vertex.ready),
    .in_ring_end (vertex.ring_end),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_area    (result.twice_area),
    .out_perim   (result.perimeter),
    .out_count   (result.corner_count)
);

>>> sim/polygon_summary_checker.sv
`timescale 1ns / 1ps
// predicts each polygon result from the cfg and vertex beats and checks every result beat
// depends on pap_pkg and the channel interfaces in pap_if
module polygon_summary_checker
    import pap_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    pap_cfg_if    cfg,
    pap_vertex_if vertex,
    pap_result_if result,
    input  logic  drain_check,
    output int    results_seen,
    output int    mismatch_count
);

    typedef struct {
        area_t  twice_area;
        perim_t perimeter;
        logic   is_hole;
        logic   is_tiny;
        count_t corner_count;
    } polygon_summary_t;

    polygon_summary_t        summaries_due[$];
    limit_t                  tiny_limit;
    coord_t                  first_x;
    coord_t                  first_y;
    coord_t                  prev_x;
    coord_t                  prev_y;
    logic signed [ACC_W-1:0] area_acc;
    perim_t                  perim_acc;
    count_t                  corners;
    int                      polygon_no;
    logic                    drain_done;

    task automatic report(input string what, input longint got, input longint want);
        $display("polygon %0d %s: got %0d, expected %0d", polygon_no, what, got, want);
        mismatch_count++;
    endtask

    function automatic longint unsigned floor_root(input longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 26; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    task automatic accumulate_edge(input coord_t ax, input coord_t ay,
                                   input coord_t bx, input coord_t by);
        longint          sx;
        longint          dx;
        longint          dy;
        longint          sum;
        longint unsigned len;
        longint unsigned per;
        sx  = longint'(ax) + longint'(bx);
        dx  = longint'(bx) - longint'(ax);
        dy  = longint'(by) - longint'(ay);
        // shoelace term, clockwise positive, clamped after every edge
        sum = longint'(area_acc) - sx * dy;
        if (sum > longint'(AREA_HI))
            sum = AREA_HI;
        else if (sum < longint'(AREA_LO))
            sum = AREA_LO;
        area_acc = sum;
        len = floor_root(dx * dx + dy * dy);
        per = perim_acc + len;
        perim_acc = (per > PERIM_SAT) ? PERIM_SAT : perim_t'(per);
    endtask

    task automatic take_vertex(input coord_t x, input coord_t y, input logic last);
        polygon_summary_t  s;
        logic [ACC_W-1:0]  mag;
        if (corners == '0)
        begin
            first_x   = x;
            first_y   = y;
            area_acc  = '0;
            perim_acc = '0;
            corners   = count_t'(1);
        end
        else
        begin
            accumulate_edge(prev_x, prev_y, x, y);
            if (corners < count_t'(MAX_CORNERS))
                corners++;
        end
        prev_x = x;
        prev_y = y;
        if (last)
        begin
            // closing edge back to the first vertex
            accumulate_edge(prev_x, prev_y, first_x, first_y);
            mag            = (area_acc < 0) ? -area_acc : area_acc;
            s.twice_area   = area_acc[AREA_W-1:0];
            s.perimeter    = perim_acc;
            s.is_hole      = (area_acc < 0);
            s.is_tiny      = (mag < {2'b00, tiny_limit});
            s.corner_count = corners;
            summaries_due.push_back(s);
            corners = '0;
        end
    endtask

    task automatic check_result();
        polygon_summary_t s;
        if (summaries_due.size() == 0)
        begin
            report("result beat with no polygon closed", result.twice_area, 0);
            return;
        end
        s = summaries_due.pop_front();
        if (result.twice_area !== s.twice_area)
            report("twice_area", result.twice_area, s.twice_area);
        if (result.perimeter !== s.perimeter)
            report("perimeter", result.perimeter, s.perimeter);
        if (result.is_hole !== s.is_hole)
            report("is_hole", result.is_hole, s.is_hole);
        if (result.is_tiny !== s.is_tiny)
            report("is_tiny", result.is_tiny, s.is_tiny);
        if (result.corner_count !== s.corner_count)
            report("corner_count", result.corner_count, s.corner_count);
        polygon_no++;
        results_seen <= results_seen + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            summaries_due.delete();
            tiny_limit     = '0;
            first_x        = '0;
            first_y        = '0;
            prev_x         = '0;
            prev_y         = '0;
            area_acc       = '0;
            perim_acc      = '0;
            corners        = '0;
            polygon_no     = 0;
            drain_done     = 1'b0;
            mismatch_count = 0;
            results_seen  <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                tiny_limit = cfg.tiny_area_limit;
            if (vertex.valid && vertex.ready)
                take_vertex(vertex.vertex_x, vertex.vertex_y, vertex.ring_end);
            if (result.valid && result.ready)
                check_result();
            if (drain_check && !drain_done)
            begin
                drain_done = 1'b1;
                if (summaries_due.size() != 0)
                    report("polygons left without a result", summaries_due.size(), 0);
            end
        end
    end

endmodule

>>> sim/polygon_area_perimeter_test.sv
`timescale 1ns / 1ps
// drives polygon vertices, limit writes and result backpressure into the area block
// depends on pap_pkg, pap_if, polygon_area_perimeter and polygon_summary_checker
module polygon_area_perimeter_test;
    import pap_pkg::*;

    localparam int     DRAIN_CYCLES = 80;
    localparam int     PHASE_ITEMS  = 650;
    localparam longint TIMEOUT_NS   = 12_000_000;
    localparam coord_t COORD_MAX    = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t COORD_MIN    = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam limit_t LIMIT_MAX    = {LIMIT_W{1'b1}};

    typedef enum int {
        SHAPE_SCATTER,
        SHAPE_CLUSTER,
        SHAPE_EXTREME,
        SHAPE_RECT
    } shape_t;

    logic clk = 1'b0;
    logic rst_n;
    logic drain_check;
    int   results_seen;
    int   mismatches;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   rings_sent;
    int   items_sent;

    pap_cfg_if    cfg_ch ();
    pap_vertex_if vertex_ch ();
    pap_result_if result_ch ();

    polygon_area_perimeter dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .vertex (vertex_ch),
        .result (result_ch)
    );

    polygon_summary_checker summary_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_ch),
        .vertex         (vertex_ch),
        .result         (result_ch),
        .drain_check    (drain_check),
        .results_seen   (results_seen),
        .mismatch_count (mismatches)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // result backpressure
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    task automatic send_vertex(input coord_t x, input coord_t y, input logic last);
        while ($urandom_range(99) < src_idle_pct)
        begin
            vertex_ch.valid <= 1'b0;
            @(posedge clk);
        end
        vertex_ch.valid    <= 1'b1;
        vertex_ch.vertex_x <= x;
        vertex_ch.vertex_y <= y;
        vertex_ch.ring_end <= last;
        @(posedge clk);
        while (vertex_ch.ready !== 1'b1)
            @(posedge clk);
        items_sent++;
        if (last)
            rings_sent++;
    endtask

    // hold the vertex channel until every closed polygon has its result
    task automatic settle(input logic with_tail);
        vertex_ch.valid <= 1'b0;
        @(posedge clk);
        while (rings_sent != results_seen)
            @(posedge clk);
        if (with_tail)
            repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_limit(input limit_t value);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.tiny_area_limit <= value;
        @(posedge clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic coord_t pick_coord(input shape_t shape, input coord_t centre);
        case (shape)
            SHAPE_SCATTER:
                return coord_t'($urandom);
            SHAPE_CLUSTER:
                return centre + coord_t'($urandom_range(0, 1023)) - coord_t'(512);
            default:
                case ($urandom_range(6))
                    0:       return COORD_MIN;
                    1:       return COORD_MIN + coord_t'(1);
                    2:       return coord_t'(-1);
                    3:       return '0;
                    4:       return coord_t'(1);
                    5:       return COORD_MAX - coord_t'(1);
                    default: return COORD_MAX;
                endcase
        endcase
    endfunction

    task automatic send_random_polygon();
        coord_t xs[$];
        coord_t ys[$];
        coord_t cx;
        coord_t cy;
        coord_t w;
        coord_t h;
        logic   flip;
        logic   a;
        logic   b;
        int     n;
        shape_t shape;
        shape = shape_t'($urandom_range(3));
        cx    = coord_t'($urandom);
        cy    = coord_t'($urandom);
        if (shape == SHAPE_RECT)
        begin
            w    = coord_t'($urandom_range(1, 4095));
            h    = coord_t'($urandom_range(1, 4095));
            flip = 1'($urandom_range(1));
            // mirroring across the diagonal turns the winding round
            for (int k = 0; k < 4; k++)
            begin
                a = (k >= 2);
                b = (k == 1 || k == 2);
                xs.push_back(cx + ((flip ? b : a) ? w : coord_t'(0)));
                ys.push_back(cy + ((flip ? a : b) ? h : coord_t'(0)));
            end
            if ($urandom_range(3) == 0)
            begin
                xs.push_back(xs[0]);
                ys.push_back(ys[0]);
            end
        end
        else
        begin
            n = ($urandom_range(9) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
            begin
                xs.push_back(pick_coord(shape, cx));
                ys.push_back(pick_coord(shape, cy));
            end
        end
        for (int i = 0; i < xs.size(); i++)
            send_vertex(xs[i], ys[i], i == xs.size() - 1);
    endtask

    task automatic random_phase(input int src_pct, input int sink_pct, input limit_t limit);
        int first_item;
        settle(1'b1);
        src_idle_pct   = src_pct;
        sink_idle_pct <= sink_pct;
        write_limit(limit);
        first_item = items_sent;
        while (items_sent - first_item < PHASE_ITEMS)
        begin
            if ($urandom_range(29) == 0)
                settle(1'b0);
            send_random_polygon();
        end
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        drain_check            <= 1'b0;
        vertex_ch.valid        <= 1'b0;
        vertex_ch.vertex_x     <= '0;
        vertex_ch.vertex_y     <= '0;
        vertex_ch.ring_end     <= 1'b0;
        cfg_ch.valid           <= 1'b0;
        cfg_ch.tiny_area_limit <= '0;
        sink_idle_pct          <= 65;
        src_idle_pct            = 13;
        rings_sent              = 0;
        items_sent              = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // single vertex at the corner of the range, limit still at reset
        send_vertex(COORD_MAX, COORD_MIN, 1'b1);
        // full-range triangle in both windings
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, 1'b1);
        // square closed by an explicit copy of its first vertex
        send_vertex('0, '0, 1'b0);
        send_vertex('0, coord_t'(256), 1'b0);
        send_vertex(coord_t'(256), coord_t'(256), 1'b0);
        send_vertex(coord_t'(256), '0, 1'b0);
        send_vertex('0, '0, 1'b1);
        // collinear, zero area
        send_vertex(coord_t'(-1), coord_t'(-1), 1'b0);
        send_vertex('0, '0, 1'b0);
        send_vertex(coord_t'(1), coord_t'(1), 1'b1);
        // two vertices, longest edge there and back
        send_vertex(COORD_MAX, COORD_MAX, 1'b0);
        send_vertex(COORD_MIN, COORD_MIN, 1'b1);

        settle(1'b1);
        write_limit(LIMIT_MAX);
        send_vertex('0, '0, 1'b1);
        send_vertex('0, '0, 1'b0);
        send_vertex('0, coord_t'(16), 1'b0);
        send_vertex(coord_t'(16), '0, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, 1'b0);
        send_vertex(COORD_MIN, COORD_MAX, 1'b0);
        send_vertex(COORD_MAX, COORD_MAX, 1'b1);

        random_phase(13, 65, limit_t'(64'd1 << $urandom_range(16, 44)));
        random_phase(65, 13, limit_t'({$urandom, $urandom}));
        random_phase(0, 0, '0);

        settle(1'b1);
        drain_check <= 1'b1;
        @(posedge clk);
        @(posedge clk);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
